[rtl/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and codes of the button gesture and chord detector
// Holds the input kinds, event codes, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // Kinds of input item.
  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COMBO_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_MOMENTARY_MODE = 3'd1;
  localparam logic [2:0] CFG_LONG_MASK      = 3'd2;
  localparam logic [2:0] CFG_CLICK_MASK     = 3'd3;
  localparam logic [2:0] CFG_LONG_PRESS_MS  = 3'd4;
  localparam logic [2:0] CFG_COMBO_WINDOW   = 3'd5;

  localparam int CFG_DATA_W = 16;

  // The virtual button formed by the chord of buttons 0 and 1.
  localparam int COMBO_IDX = 2;

  // Most events one item can produce.
  localparam int MAX_EV = 3;

  typedef enum logic [2:0] {
    EV_PRESS      = 3'd0,
    EV_RELEASE    = 3'd1,
    EV_CLICK      = 3'd2,
    EV_CLICK_END  = 3'd3,
    EV_LONG       = 3'd4,
    EV_LONG_END   = 3'd5
  } ev_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_TICK,
    ST_CLEAR,
    ST_CHECK,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;   // load the input item, empty the event buffer
    logic       edge_op;   // apply the captured raw edge
    logic       visit;     // tick visit of one button
    logic       clear;     // zero all gesture state
    logic [1:0] emit_idx;  // event buffer slot on the output
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] ev_cnt;    // events held in the buffer
    logic       last;      // emit_idx points at the final event
  } dp_stat_t;

endpackage

[rtl/bgc_ctrl.sv]
// ----------------------------------------------------------------------------
// bgc_ctrl: sequencing controller of the button gesture and chord detector
// Accepts an item, steps the datapath through the edge, tick visits or clear,
// then hands the buffered events out one transfer at a time.
// ----------------------------------------------------------------------------
module bgc_ctrl import bgc_pkg::*; #(
  parameter int BUTTON_TOTAL = 3,
  parameter int BW           = $clog2(BUTTON_TOTAL)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    kind_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dp_cmd_t       cmd_o,
  output logic [BW-1:0] visit_idx_o,
  input  dp_stat_t      stat_i
);

  localparam logic [BW-1:0] LastBtn = BW'(BUTTON_TOTAL - 1);

  ctrl_state_e   state_q, state_d;
  logic [BW-1:0] visit_q, visit_d;
  logic [1:0]    emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      visit_q <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      visit_q <= visit_d;
      emit_q  <= emit_d;
    end
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    visit_d = visit_q;
    emit_d  = emit_q;
    unique case (state_q)
      ST_IDLE: begin
        visit_d = '0;
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_EDGE:  state_d = ST_EDGE;
            KIND_TICK:  state_d = ST_TICK;
            KIND_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE:  state_d = ST_CHECK;
      ST_TICK: begin
        if (visit_q == LastBtn) begin
          state_d = ST_CHECK;
          visit_d = '0;
        end else begin
          visit_d = visit_q + BW'(1);
        end
      end
      ST_CLEAR: state_d = ST_IDLE;
      ST_CHECK: begin
        emit_d  = '0;
        state_d = (stat_i.ev_cnt == 2'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + 2'd1;
          end
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.emit_idx = emit_q;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EDGE:  cmd_o.edge_op = 1'b1;
      ST_TICK:  cmd_o.visit   = 1'b1;
      ST_CLEAR: cmd_o.clear   = 1'b1;
      ST_CHECK: ;
      ST_EMIT:  out_valid_o   = 1'b1;
      default:  ;
    endcase
  end

  assign visit_idx_o = visit_q;

endmodule

[rtl/bgc_dpath.sv]
// ----------------------------------------------------------------------------
// bgc_dpath: datapath of the button gesture and chord detector
// Holds configuration, per-button gesture state, the captured item and the
// event buffer, and applies one edge or one button visit per command.
// ----------------------------------------------------------------------------
module bgc_dpath import bgc_pkg::*; #(
  parameter int BUTTON_TOTAL = 3,
  parameter int BW           = $clog2(BUTTON_TOTAL)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            button_i,
  input  logic                  is_pressed_i,
  input  logic [31:0]           now_ms_i,
  input  dp_cmd_t               cmd_i,
  input  logic [BW-1:0]         visit_idx_i,
  output dp_stat_t              stat_o,
  output logic [1:0]            event_button_o,
  output logic [2:0]            event_code_o,
  output logic                  last_event_o
);

  localparam logic [BW-1:0] ComboBtn = BW'(COMBO_IDX);
  localparam logic [1:0]    EvFull   = 2'(MAX_EV);

  // Configuration.
  logic        combo_en_q, mom_q;
  logic [2:0]  long_mask_q, click_mask_q;
  logic [15:0] long_ms_q;
  logic [9:0]  window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combo_en_q   <= 1'b0;
      mom_q        <= 1'b0;
      long_mask_q  <= '0;
      click_mask_q <= '0;
      long_ms_q    <= 16'd1000;
      window_q     <= 10'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COMBO_ENABLE:   combo_en_q   <= cfg_data_i[0];
        CFG_MOMENTARY_MODE: mom_q        <= cfg_data_i[0];
        CFG_LONG_MASK:      long_mask_q  <= cfg_data_i[2:0];
        CFG_CLICK_MASK:     click_mask_q <= cfg_data_i[2:0];
        CFG_LONG_PRESS_MS:  long_ms_q    <= cfg_data_i[15:0];
        CFG_COMBO_WINDOW:   window_q     <= cfg_data_i[9:0];
        default:            ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]  btn_q;
  logic        pressed_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      btn_q     <= button_i;
      pressed_q <= is_pressed_i;
      now_q     <= now_ms_i;
    end
  end

  // Gesture state.
  logic [BUTTON_TOTAL-1:0] pend_q, pend_d, cons_q, cons_d, down_q, down_d;
  logic [BUTTON_TOTAL-1:0] longf_q, longf_d, clickf_q, clickf_d;
  logic                    combo_q, combo_d;
  logic [31:0]             pt_q [BUTTON_TOTAL];

  // Event buffer.
  logic [1:0] ev_cnt_q, ev_cnt_d;
  logic [1:0] ev_btn_q  [MAX_EV];
  logic [1:0] ev_btn_d  [MAX_EV];
  ev_code_e   ev_code_q [MAX_EV];
  ev_code_e   ev_code_d [MAX_EV];

  // Timestamp write port.
  logic          pt_we;
  logic [BW-1:0] pt_widx;
  logic [31:0]   pt_wdata;

  function automatic logic mask_bit(input logic [2:0] mask, input logic [BW-1:0] b);
    logic r;
    r = 1'b0;
    if (32'(b) < 32'd3) begin
      r = mask[b[1:0]];
    end
    return r;
  endfunction

  logic          btn_ok;
  logic [BW-1:0] bidx, oidx;
  logic [31:0]   pt_rd, elapsed;
  logic          win_hit, long_hit;
  logic          do_press, do_release;
  logic [BW-1:0] press_idx, rel_idx;
  logic [31:0]   press_t;

  assign btn_ok   = 32'(btn_q) < 32'(BUTTON_TOTAL);
  assign bidx     = BW'(btn_q);
  assign oidx     = BW'({1'b0, ~btn_q[0]});
  assign pt_rd    = pt_q[visit_idx_i];
  assign elapsed  = now_q - pt_rd;
  assign win_hit  = elapsed >= 32'(window_q);
  assign long_hit = elapsed >= 32'(long_ms_q);

  always_comb begin
    pend_d     = pend_q;
    cons_d     = cons_q;
    down_d     = down_q;
    longf_d    = longf_q;
    clickf_d   = clickf_q;
    combo_d    = combo_q;
    ev_cnt_d   = ev_cnt_q;
    ev_btn_d   = ev_btn_q;
    ev_code_d  = ev_code_q;
    do_press   = 1'b0;
    do_release = 1'b0;
    press_idx  = bidx;
    rel_idx    = bidx;
    press_t    = now_q;

    // Decide what the edge or the visit does.
    if (cmd_i.edge_op && btn_ok) begin
      if (pressed_q) begin
        if (combo_en_q && btn_q < 2'(COMBO_IDX)) begin
          if (pend_q[oidx]) begin
            pend_d[oidx] = 1'b0;
            cons_d[bidx] = 1'b1;
            cons_d[oidx] = 1'b1;
            combo_d      = 1'b1;
            do_press     = 1'b1;
            press_idx    = ComboBtn;
          end else begin
            pend_d[bidx] = 1'b1;
          end
        end else begin
          do_press = 1'b1;
        end
      end else if (pend_q[bidx]) begin
        pend_d[bidx] = 1'b0;
        do_press     = 1'b1;
        do_release   = 1'b1;
      end else if (cons_q[bidx]) begin
        cons_d[bidx] = 1'b0;
        if (combo_q) begin
          combo_d    = 1'b0;
          do_release = 1'b1;
          rel_idx    = ComboBtn;
        end
      end else begin
        do_release = 1'b1;
      end
    end else if (cmd_i.visit) begin
      if (ev_cnt_q != EvFull && pend_q[visit_idx_i] && win_hit) begin
        pend_d[visit_idx_i] = 1'b0;
        do_press            = 1'b1;
        press_idx           = visit_idx_i;
        press_t             = pt_rd;
      end
    end

    // Logical press.
    if (do_press) begin
      down_d[press_idx]   = 1'b1;
      longf_d[press_idx]  = 1'b0;
      clickf_d[press_idx] = 1'b0;
      if (!mom_q) begin
        ev_btn_d[ev_cnt_d]  = press_idx[1:0];
        ev_code_d[ev_cnt_d] = EV_PRESS;
        ev_cnt_d            = ev_cnt_d + 2'd1;
      end else if (mask_bit(click_mask_q, press_idx) || !mask_bit(long_mask_q, press_idx)) begin
        clickf_d[press_idx] = 1'b1;
        ev_btn_d[ev_cnt_d]  = press_idx[1:0];
        ev_code_d[ev_cnt_d] = EV_CLICK;
        ev_cnt_d            = ev_cnt_d + 2'd1;
      end
    end

    // Logical release, seeing the effect of a press in the same step.
    if (do_release && down_d[rel_idx]) begin
      down_d[rel_idx]    = 1'b0;
      ev_btn_d[ev_cnt_d] = rel_idx[1:0];
      if (!mom_q) begin
        ev_code_d[ev_cnt_d] = EV_RELEASE;
      end else if (longf_d[rel_idx]) begin
        ev_code_d[ev_cnt_d] = EV_LONG_END;
      end else if (clickf_d[rel_idx]) begin
        ev_code_d[ev_cnt_d] = EV_CLICK_END;
      end else begin
        ev_code_d[ev_cnt_d] = EV_CLICK;
      end
      ev_cnt_d = ev_cnt_d + 2'd1;
    end

    // Long press check of the visited button.
    if (cmd_i.visit && ev_cnt_d != EvFull && down_d[visit_idx_i] && mom_q &&
        mask_bit(long_mask_q, visit_idx_i) && !longf_d[visit_idx_i] &&
        !clickf_d[visit_idx_i] && long_hit) begin
      longf_d[visit_idx_i] = 1'b1;
      ev_btn_d[ev_cnt_d]   = visit_idx_i[1:0];
      ev_code_d[ev_cnt_d]  = EV_LONG;
      ev_cnt_d             = ev_cnt_d + 2'd1;
    end

    if (cmd_i.capture) begin
      ev_cnt_d = '0;
    end
  end

  // A pending press stores its time, also when the button was already
  // pending; a logical press stores its own.
  always_comb begin
    pt_we    = do_press;
    pt_widx  = press_idx;
    pt_wdata = press_t;
    if (cmd_i.edge_op && btn_ok && pressed_q && !do_press) begin
      pt_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      cons_q   <= '0;
      down_q   <= '0;
      longf_q  <= '0;
      clickf_q <= '0;
      combo_q  <= 1'b0;
      ev_cnt_q <= '0;
      for (int i = 0; i < BUTTON_TOTAL; i++) begin
        pt_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      pend_q   <= '0;
      cons_q   <= '0;
      down_q   <= '0;
      longf_q  <= '0;
      clickf_q <= '0;
      combo_q  <= 1'b0;
      ev_cnt_q <= '0;
      for (int i = 0; i < BUTTON_TOTAL; i++) begin
        pt_q[i] <= '0;
      end
    end else begin
      pend_q   <= pend_d;
      cons_q   <= cons_d;
      down_q   <= down_d;
      longf_q  <= longf_d;
      clickf_q <= clickf_d;
      combo_q  <= combo_d;
      ev_cnt_q <= ev_cnt_d;
      if (pt_we) begin
        pt_q[pt_widx] <= pt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_btn_q  <= ev_btn_d;
    ev_code_q <= ev_code_d;
  end

  assign stat_o.ev_cnt = ev_cnt_q;
  assign stat_o.last   = (cmd_i.emit_idx + 2'd1) == ev_cnt_q;
  assign event_button_o = ev_btn_q[cmd_i.emit_idx];
  assign event_code_o   = ev_code_q[cmd_i.emit_idx];
  assign last_event_o   = stat_o.last;

endmodule

[rtl/button_gesture_combo_detector_top.sv]
// ----------------------------------------------------------------------------
// button_gesture_combo_detector_top: button gesture and chord detector
// Turns raw button edges and millisecond ticks into press, release, click and
// long press events, with buttons 0 and 1 optionally merged into button 2.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   kind_i, button_i, is_pressed_i,
//                                                  now_ms_i
//   out       output     out_valid_o / out_stall_i event_button_o, event_code_o,
//                                                  last_event_o
//   cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// An item is taken in the idle state; a raw edge is then applied, or a tick
// visits the buttons one per cycle through a single elapsed-time subtractor.
// The event count is then checked, and each event takes one transfer;
// one item is worked at a time.
// Reset clears all gesture state and loads the register defaults at once.
// A stalled output holds its event; the input stays stalled until the last
// event of the current item has been transferred.
//
module button_gesture_combo_detector_top import bgc_pkg::*; #(
  parameter int BUTTON_TOTAL = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  input  logic [1:0]            button_i,
  input  logic                  is_pressed_i,
  input  logic [31:0]           now_ms_i,
  // Result events.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_button_o,
  output logic [2:0]            event_code_o,
  output logic                  last_event_o
);

  // Width of a button index into the per-button state.
  localparam int BW = $clog2(BUTTON_TOTAL);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [BW-1:0] visit_idx;

  // The controller sequences each item: capture, then an edge or per-button
  // visits followed by a count check and one transfer per buffered event, or a clear.
  bgc_ctrl #(
    .BUTTON_TOTAL (BUTTON_TOTAL),
    .BW           (BW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .visit_idx_o (visit_idx),
    .stat_i      (stat)
  );

  // The datapath holds the registers, the per-button flags and timestamps,
  // and the event buffer that the output channel reads from.
  bgc_dpath #(
    .BUTTON_TOTAL (BUTTON_TOTAL),
    .BW           (BW)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .button_i       (button_i),
    .is_pressed_i   (is_pressed_i),
    .now_ms_i       (now_ms_i),
    .cmd_i          (cmd),
    .visit_idx_i    (visit_idx),
    .stat_o         (stat),
    .event_button_o (event_button_o),
    .event_code_o   (event_code_o),
    .last_event_o   (last_event_o)
  );

endmodule

[sim/button_gesture_combo_detector_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_combo_detector_top_test: regression bench of the gesture detector
// Drives raw edges, ticks, clears and ignored items through the input channel.
// A built-in gesture tracker predicts the events of every accepted item and
// checks each event transfer in order. The run covers several register
// settings under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module button_gesture_combo_detector_top_test;
  import bgc_pkg::*;

  localparam int BUTTON_TOTAL = 3;
  // Kind 3 has no meaning in the block and must be dropped silently.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Register indexes past the last register; writes to them must do nothing.
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  // An item that gives no event still passes through the controller states, so
  // this many quiet cycles means the block is surely idle.
  localparam int SETTLE_CYCLES = 16;
  // Cycles without any transfer on either channel before the run is declared
  // hung. Covers the longest receiver stall and sender gap with wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_SET = 67;

  // One expected event, in the order the block must present it.
  typedef struct {
    logic [1:0] btn;
    ev_code_e   code;
    logic       last;
  } gesture_ev_t;

  // Tracks the gesture state of all buttons, predicts the events caused by
  // each accepted item and compares the observed event transfers against them.
  class gesture_tracker;
    bit          combo_en;
    bit          moment;
    bit [2:0]    long_mask;
    bit [2:0]    click_mask;
    bit [15:0]   long_ms;
    bit [9:0]    window_ms;

    bit          pending[BUTTON_TOTAL];
    bit          consumed[BUTTON_TOTAL];
    bit          down[BUTTON_TOTAL];
    bit          long_fired[BUTTON_TOTAL];
    bit          click_fired[BUTTON_TOTAL];
    bit [31:0]   t_press[BUTTON_TOTAL];
    bit          chord_active;

    gesture_ev_t step_ev[$];
    gesture_ev_t due_events[$];
    int          errors;

    function new();
      combo_en   = 1'b0;
      moment     = 1'b0;
      long_mask  = '0;
      click_mask = '0;
      long_ms    = 16'd1000;
      window_ms  = 10'd50;
      errors     = 0;
      clear_gestures();
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_COMBO_ENABLE:   combo_en   = val[0];
        CFG_MOMENTARY_MODE: moment     = val[0];
        CFG_LONG_MASK:      long_mask  = val[2:0];
        CFG_CLICK_MASK:     click_mask = val[2:0];
        CFG_LONG_PRESS_MS:  long_ms    = val;
        CFG_COMBO_WINDOW:   window_ms  = val[9:0];
        default: ;
      endcase
    endfunction

    function void clear_gestures();
      for (int i = 0; i < BUTTON_TOTAL; i++) begin
        pending[i]     = 1'b0;
        consumed[i]    = 1'b0;
        down[i]        = 1'b0;
        long_fired[i]  = 1'b0;
        click_fired[i] = 1'b0;
        t_press[i]     = '0;
      end
      chord_active = 1'b0;
    endfunction

    // Events beyond the per-item limit are simply lost.
    function void emit(int b, ev_code_e code);
      gesture_ev_t ev;
      if (step_ev.size() < MAX_EV) begin
        ev.btn  = b[1:0];
        ev.code = code;
        ev.last = 1'b0;
        step_ev = {step_ev, ev};
      end
    endfunction

    function void logical_press(int b, bit [31:0] t);
      down[b]        = 1'b1;
      t_press[b]     = t;
      long_fired[b]  = 1'b0;
      click_fired[b] = 1'b0;
      if (!moment) begin
        emit(b, EV_PRESS);
      end else if (click_mask[b] || !long_mask[b]) begin
        click_fired[b] = 1'b1;
        emit(b, EV_CLICK);
      end
    endfunction

    function void logical_release(int b);
      if (!down[b]) return;
      down[b] = 1'b0;
      if (!moment) emit(b, EV_RELEASE);
      else if (long_fired[b]) emit(b, EV_LONG_END);
      else if (click_fired[b]) emit(b, EV_CLICK_END);
      else emit(b, EV_CLICK);
    endfunction

    function void raw_edge(int b, bit p, bit [31:0] t);
      int other;
      if (b >= BUTTON_TOTAL) return;
      if (p) begin
        if (combo_en && b < COMBO_IDX) begin
          other = 1 - b;
          if (pending[other]) begin
            // The partner is still held back, so the two presses form a chord.
            pending[other]  = 1'b0;
            consumed[b]     = 1'b1;
            consumed[other] = 1'b1;
            chord_active    = 1'b1;
            logical_press(COMBO_IDX, t);
          end else begin
            pending[b] = 1'b1;
            t_press[b] = t;
          end
        end else begin
          logical_press(b, t);
        end
      end else if (pending[b]) begin
        // A tap released inside the window becomes a full press and release.
        pending[b] = 1'b0;
        logical_press(b, t);
        logical_release(b);
      end else if (consumed[b]) begin
        consumed[b] = 1'b0;
        if (chord_active) begin
          chord_active = 1'b0;
          logical_release(COMBO_IDX);
        end
      end else begin
        logical_release(b);
      end
    endfunction

    // The visit stops once the event limit is reached; what is left over
    // fires on a later tick.
    function void visit_tick(bit [31:0] t);
      bit [31:0] elapsed;
      for (int i = 0; i < BUTTON_TOTAL; i++) begin
        if (step_ev.size() >= MAX_EV) return;
        elapsed = t - t_press[i];
        if (pending[i] && elapsed >= window_ms) begin
          pending[i] = 1'b0;
          logical_press(i, t_press[i]);
        end
        if (step_ev.size() >= MAX_EV) return;
        if (down[i] && moment && long_mask[i] && !long_fired[i] && !click_fired[i] &&
            elapsed >= long_ms) begin
          long_fired[i] = 1'b1;
          emit(i, EV_LONG);
        end
      end
    endfunction

    function void apply_item(logic [1:0] k, logic [1:0] b, logic p, logic [31:0] t);
      step_ev.delete();
      case (k)
        KIND_EDGE:  raw_edge(int'(b), p, t);
        KIND_TICK:  visit_tick(t);
        KIND_CLEAR: clear_gestures();
        default: ;
      endcase
      foreach (step_ev[i]) begin
        step_ev[i].last = (i == step_ev.size() - 1);
        due_events = {due_events, step_ev[i]};
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_event(logic [1:0] btn, logic [2:0] code, logic last);
      gesture_ev_t want;
      if (due_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event button %0d code %0d last %0d",
                                btn, code, last));
        return;
      end
      want = due_events.pop_front();
      if (btn !== want.btn)
        flag_mismatch($sformatf("event button %0d, expected %0d", btn, want.btn));
      if (code !== want.code)
        flag_mismatch($sformatf("event code %0d, expected %s", code, want.code.name()));
      if (last !== want.last)
        flag_mismatch($sformatf("last flag %0d, expected %0d", last, want.last));
    endtask
  endclass

  // Every input starts at a known value; the clock toggles every half period.
  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [2:0]            cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            kind         = '0;
  logic [1:0]            button       = '0;
  logic                  pressed      = 1'b0;
  logic [31:0]           now_ms       = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            event_button;
  logic [2:0]            event_code;
  logic                  last_event;

  gesture_tracker tracker = new();

  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  int          quiet_cycles = 0;
  int          cfg_round    = 0;
  bit [31:0]   clock_ms     = '0;
  bit          raw_held[4];

  always #6 clk = ~clk;

  button_gesture_combo_detector_top #(
    .BUTTON_TOTAL(BUTTON_TOTAL)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .button_i      (button),
    .is_pressed_i  (pressed),
    .now_ms_i      (now_ms),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_button_o(event_button),
    .event_code_o  (event_code),
    .last_event_o  (last_event)
  );

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Both channels are sampled at the clock edge, before any of this edge's
  // nonblocking updates land. Output transfers are checked before the input
  // transfer of the same edge is predicted, which keeps the expected order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_event(event_button, event_code, last_event);
      if (in_valid && !in_stall)
        tracker.apply_item(kind, button, pressed, now_ms);
    end
  end

  // The watchdog ends a run that stops making progress on both channels.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("button_gesture_combo_detector_top regression: fail");
      $finish;
    end
  end

  // Presents one item after a random gap and holds it until the transfer.
  // Every call starts and ends right after a rising edge, so valid stays high
  // between back-to-back items and is only lowered when a gap is taken.
  task automatic send_item(logic [1:0] k, logic [1:0] b, logic p, logic [31:0] t);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    button   <= b;
    pressed  <= p;
    now_ms   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every predicted event has been seen, then
  // lets the block finish any item that produced no event.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // Writes all six registers while the block is idle. Narrow registers get
  // random upper bits, which the block must drop. One of the unmapped indexes
  // is also written each time and must leave every setting alone.
  task automatic program_regs(bit ce, bit mm, bit [2:0] lm, bit [2:0] cm,
                              bit [15:0] lp, bit [9:0] cw);
    drain_events();
    write_reg(CFG_COMBO_ENABLE,   {15'($urandom), ce});
    write_reg(CFG_MOMENTARY_MODE, {15'($urandom), mm});
    write_reg(CFG_LONG_MASK,      {13'($urandom), lm});
    write_reg(CFG_CLICK_MASK,     {13'($urandom), cm});
    write_reg(CFG_LONG_PRESS_MS,  lp);
    write_reg(CFG_COMBO_WINDOW,   {6'($urandom), cw});
    write_reg(cfg_round[0] ? CFG_SPARE_B : CFG_SPARE_A, 16'($urandom));
    cfg_we <= 1'b0;
    cfg_round++;
  endtask

  // Settings of the random part; the extremes of the long press time, window
  // values of 0 and 1000 and both modes appear among them.
  task automatic program_set(int sel);
    case (sel)
      0: program_regs(1'b1, 1'b1, 3'd7, 3'd0, 16'd300, 10'd50);
      1: program_regs(1'b1, 1'b0, 3'($urandom), 3'($urandom), 16'd0, 10'd1000);
      2: program_regs(1'b0, 1'b1, 3'd5, 3'd2, 16'd65535, 10'd0);
      3: program_regs(1'b1, 1'b1, 3'd3, 3'd1, 16'd0, 10'd0);
      4: program_regs(1'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                      16'($urandom_range(0, 3000)), 10'($urandom_range(0, 1000)));
      default: program_regs(1'b1, 1'b1, 3'($urandom), 3'($urandom),
                            16'($urandom_range(0, 2000)), 10'($urandom_range(0, 1000)));
    endcase
  endtask

  // Time steps are mostly short, so chords and taps land inside the window,
  // with some long enough to cross the window or the long press time.
  function automatic int unsigned pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 30);
    if (r < 80) return $urandom_range(0, int'(tracker.window_ms) + 30);
    return $urandom_range(0, int'(tracker.long_ms) + 100);
  endfunction

  // Most items are alternating presses and releases of real buttons and
  // ticks in between; the rest are repeated levels, clears, dropped items
  // and jumps of the clock to any 32-bit value.
  task automatic random_item(output bit counted);
    int   r;
    int   b;
    logic p;
    r       = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 45) begin
      clock_ms += pick_step();
      send_item(KIND_TICK, 2'($urandom), 1'($urandom), clock_ms);
    end else if (r < 90) begin
      b = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
      p = (r < 85) ? !raw_held[b] : raw_held[b];
      raw_held[b] = p;
      clock_ms += pick_step();
      counted = (b < BUTTON_TOTAL);
      send_item(KIND_EDGE, 2'(b), p, clock_ms);
    end else if (r < 93) begin
      send_item(KIND_CLEAR, 2'($urandom), 1'($urandom), clock_ms);
    end else if (r < 95) begin
      counted = 1'b0;
      send_item(KIND_UNUSED, 2'($urandom), 1'($urandom), 32'($urandom));
    end else begin
      clock_ms = $urandom();
      send_item(KIND_TICK, 2'($urandom), 1'($urandom), clock_ms);
    end
  endtask

  initial begin
    int done;
    bit counted;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part. Reset settings give latching mode without chords: a
    // press and a release, then an out-of-range button, the unused kind and
    // a release of a button that is not down, none of which gives an event.
    send_item(KIND_EDGE, 2'd0, 1'b1, 32'd0);
    send_item(KIND_EDGE, 2'd0, 1'b0, 32'd5);
    send_item(KIND_EDGE, 2'd3, 1'b1, 32'd6);
    send_item(KIND_UNUSED, 2'd2, 1'b1, 32'd7);
    send_item(KIND_EDGE, 2'd2, 1'b0, 32'd8);

    // Momentary mode with chords on. Buttons 0 and 1 form a chord, then a
    // held tap ripens on the window edge and later turns into a long press,
    // then a quick tap of each button, then a clear while button 2 is down.
    program_regs(1'b1, 1'b1, 3'b011, 3'b010, 16'd100, 10'd50);
    send_item(KIND_EDGE, 2'd0, 1'b1, 32'd1000);
    send_item(KIND_EDGE, 2'd1, 1'b1, 32'd1020);
    send_item(KIND_EDGE, 2'd0, 1'b0, 32'd1100);
    send_item(KIND_EDGE, 2'd1, 1'b0, 32'd1110);
    send_item(KIND_EDGE, 2'd0, 1'b1, 32'd2000);
    send_item(KIND_TICK, 2'd3, 1'b1, 32'd2049);
    send_item(KIND_TICK, 2'd0, 1'b0, 32'd2050);
    send_item(KIND_TICK, 2'd1, 1'b0, 32'd2100);
    send_item(KIND_EDGE, 2'd0, 1'b0, 32'd2200);
    send_item(KIND_EDGE, 2'd1, 1'b1, 32'd3000);
    send_item(KIND_EDGE, 2'd1, 1'b0, 32'd3010);
    send_item(KIND_EDGE, 2'd0, 1'b1, 32'd4000);
    send_item(KIND_EDGE, 2'd0, 1'b0, 32'd4010);
    send_item(KIND_EDGE, 2'd2, 1'b1, 32'd4100);
    send_item(KIND_CLEAR, 2'd1, 1'b1, 32'd4150);
    send_item(KIND_EDGE, 2'd2, 1'b0, 32'd4200);

    // All three buttons held across the 32-bit wrap of the clock: one tick
    // gives the most events an item can carry, three long presses.
    program_regs(1'b0, 1'b1, 3'b111, 3'b000, 16'd16, 10'd0);
    send_item(KIND_EDGE, 2'd0, 1'b1, 32'hFFFF_FFF0);
    send_item(KIND_EDGE, 2'd1, 1'b1, 32'hFFFF_FFF8);
    send_item(KIND_EDGE, 2'd2, 1'b1, 32'hFFFF_FFFC);
    send_item(KIND_TICK, 2'd2, 1'b1, 32'h0000_0010);
    send_item(KIND_EDGE, 2'd0, 1'b0, 32'h0000_0020);
    send_item(KIND_EDGE, 2'd1, 1'b0, 32'h0000_0021);
    send_item(KIND_EDGE, 2'd2, 1'b0, 32'h0000_0022);
    clock_ms = 32'h0000_0100;

    // Random part in three idling phases: a slow receiver, then a slow
    // sender, then full rate. Each phase runs two register settings, and the
    // sender stops once mid-way through each setting until every event is out.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 29;
          stall_pct    = 82;
        end
        1: begin
          send_gap_pct = 82;
          stall_pct    = 29;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      for (int h = 0; h < 2; h++) begin
        program_set(ph * 2 + h);
        done = 0;
        while (done < ITEMS_PER_SET) begin
          random_item(counted);
          if (counted) begin
            done++;
            if (done == ITEMS_PER_SET / 2) drain_events();
          end
        end
      end
    end

    // Wait for the last events, then for any item still being worked.
    drain_events();
    if (tracker.errors == 0)
      $display("button_gesture_combo_detector_top regression: pass");
    else
      $display("button_gesture_combo_detector_top regression: fail");
    $finish;
  end

endmodule
